// ----- rtl/tsd_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tsd_pkg
// Shared types, codes and constants of the tcp segment deframer.
// ----------------------------------------------------------------------------
package tsd_pkg;

  // packet byte counter width
  localparam int unsigned TSD_TOTAL_COUNT_WIDTH = 32;

  // header layout
  localparam int unsigned HDR_BYTES    = 12;
  localparam logic [3:0]  HDR_LAST_IDX = 4'(HDR_BYTES - 1);
  localparam logic [3:0]  HDR_LEN_IDX  = 4'd4;
  localparam logic [7:0]  TC_TAIL_BYTE = 8'h02;
  localparam logic [63:0] TC_LENGTH    = 64'd2;

  // segment types
  localparam logic [7:0] SEG_FINAL     = 8'h00;
  localparam logic [7:0] SEG_ABORT     = 8'h01;
  localparam logic [7:0] SEG_CONTINUED = 8'h02;
  localparam logic [7:0] SEG_TIMECODE  = 8'h31;

  // register indexes
  localparam logic [7:0] REG_BUFFER_CAPACITY  = 8'd0;
  localparam logic [7:0] REG_ENFORCE_CAPACITY = 8'd1;

  // register reset values
  localparam logic [31:0] CAPACITY_RESET = 32'd4096;
  localparam logic        ENFORCE_RESET  = 1'b1;

  typedef enum logic [1:0] {
    EVT_PAYLOAD  = 2'd0,
    EVT_TIMECODE = 2'd1,
    EVT_ERROR    = 2'd2
  } event_e;

  typedef enum logic {
    ERR_BAD_MESSAGE = 1'b0,
    ERR_NO_BUFFER   = 1'b1
  } err_e;

  typedef struct packed {
    logic [31:0] capacity;
    logic        enforce;
  } cfg_t;

  typedef struct packed {
    event_e      evt;
    logic [7:0]  data;
    logic        last;
    logic [31:0] length;
    err_e        err;
  } res_t;

endpackage : tsd_pkg
`default_nettype wire

// ----- rtl/tsd_in_stage.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tsd_in_stage
// Input register: holds one received byte until the parser consumes it.
// ----------------------------------------------------------------------------
module tsd_in_stage (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       valid_i,
  output logic            ready_o,
  input  wire logic [7:0] byte_i,
  input  wire logic       advance_i,
  output logic            valid_o,
  output logic [7:0]      byte_o
);

  logic       valid_q;
  logic [7:0] byte_q;

  // free when empty or when the held byte moves on this cycle
  assign ready_o = !valid_q || advance_i;

  // valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  // payload, no reset
  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      byte_q <= byte_i;
    end
  end

  assign valid_o = valid_q;
  assign byte_o  = byte_q;

endmodule : tsd_in_stage
`default_nettype wire

// ----- rtl/tsd_parser.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tsd_parser
// Header parsing, length checks and payload tracking, one byte per cycle when advanced.
// ----------------------------------------------------------------------------
module tsd_parser
  import tsd_pkg::*;
#(
  parameter int unsigned TOTAL_COUNT_WIDTH = TSD_TOTAL_COUNT_WIDTH
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       advance_i,
  input  wire logic [7:0] byte_i,
  input  wire cfg_t       cfg_i,
  output logic            res_valid_o,
  output res_t            res_o
);

  typedef enum logic [1:0] {
    PH_HEADER   = 2'd0,
    PH_PAYLOAD  = 2'd1,
    PH_SKIP     = 2'd2,
    PH_TIMECODE = 2'd3
  } phase_e;

  localparam logic [TOTAL_COUNT_WIDTH-1:0] TOTAL_MAX = '1;

  phase_e                       phase_q, phase_d;
  logic [3:0]                   hdr_idx_q, hdr_idx_d;
  logic [7:0]                   seg_type_q, seg_type_d;
  logic                         hdr_fault_q, hdr_fault_d;
  logic                         tc_fault_q, tc_fault_d;
  logic [63:0]                  len_q, len_d;
  logic [63:0]                  remain_q, remain_d;
  logic [TOTAL_COUNT_WIDTH-1:0] total_q, total_d;
  logic [7:0]                   tc_value_q, tc_value_d;

  // header values including the current byte
  logic [7:0]                   seg_n;
  logic                         hdr_fault_n;
  logic                         tc_fault_n;
  logic [63:0]                  len_base;
  logic [63:0]                  len_n;
  logic [63:0]                  total_wide;
  logic [63:0]                  cap_wide;
  logic [63:0]                  room;
  logic [TOTAL_COUNT_WIDTH-1:0] total_inc;
  logic [63:0]                  total_inc_wide;
  logic                         fail;
  err_e                         fail_code;

  // header byte folding
  always_comb begin
    seg_n       = (hdr_idx_q == '0) ? byte_i : seg_type_q;
    hdr_fault_n = hdr_fault_q;
    tc_fault_n  = tc_fault_q;
    len_base    = len_q;
    if (hdr_idx_q == '0) begin
      hdr_fault_n = !(byte_i == SEG_FINAL || byte_i == SEG_ABORT ||
                      byte_i == SEG_CONTINUED || byte_i == SEG_TIMECODE);
      tc_fault_n  = 1'b0;
      len_base    = '0;
    end else if (hdr_idx_q == 4'd1) begin
      hdr_fault_n = hdr_fault_q || (byte_i != 8'h00);
    end else if (hdr_idx_q == HDR_LAST_IDX) begin
      tc_fault_n  = tc_fault_q || (byte_i != TC_TAIL_BYTE);
    end else begin
      tc_fault_n  = tc_fault_q || (byte_i != 8'h00);
    end
    len_n = (hdr_idx_q >= HDR_LEN_IDX) ? {len_base[55:0], byte_i} : len_base;
  end

  // remaining capacity and saturating byte count
  assign total_wide     = 64'(total_q);
  assign cap_wide       = 64'(cfg_i.capacity);
  assign room           = (total_wide <= cap_wide) ? (cap_wide - total_wide) : '0;
  assign total_inc      = (total_q != TOTAL_MAX) ? (total_q + TOTAL_COUNT_WIDTH'(1)) : total_q;
  assign total_inc_wide = 64'(total_inc);

  // next state and result
  always_comb begin
    phase_d     = phase_q;
    hdr_idx_d   = hdr_idx_q;
    seg_type_d  = seg_type_q;
    hdr_fault_d = hdr_fault_q;
    tc_fault_d  = tc_fault_q;
    len_d       = len_q;
    remain_d    = remain_q;
    total_d     = total_q;
    tc_value_d  = tc_value_q;
    fail        = 1'b0;
    fail_code   = ERR_BAD_MESSAGE;
    res_valid_o = 1'b0;
    res_o       = '{evt: EVT_PAYLOAD, data: '0, last: 1'b0, length: '0,
                    err: ERR_BAD_MESSAGE};
    case (phase_q)
      PH_HEADER: begin
        seg_type_d  = seg_n;
        hdr_fault_d = hdr_fault_n;
        tc_fault_d  = tc_fault_n;
        len_d       = len_n;
        if (hdr_idx_q != HDR_LAST_IDX) begin
          hdr_idx_d = hdr_idx_q + 4'd1;
        end else begin
          hdr_idx_d = '0;
          if (hdr_fault_n || len_n == '0) begin
            fail = 1'b1;
          end else if (cfg_i.enforce && len_n > room) begin
            fail      = 1'b1;
            fail_code = ERR_NO_BUFFER;
          end else begin
            remain_d = len_n;
            if (seg_n == SEG_TIMECODE) begin
              if (tc_fault_n) begin
                fail = 1'b1;
              end else begin
                phase_d = PH_TIMECODE;
              end
            end else if (seg_n == SEG_ABORT) begin
              phase_d = PH_SKIP;
            end else begin
              phase_d = PH_PAYLOAD;
            end
          end
        end
      end
      PH_PAYLOAD: begin
        remain_d    = remain_q - 64'd1;
        total_d     = total_inc;
        res_valid_o = 1'b1;
        res_o.data  = byte_i;
        res_o.length = total_inc_wide[31:0];
        if (remain_q == 64'd1) begin
          phase_d = PH_HEADER;
          if (seg_type_q == SEG_FINAL) begin
            res_o.last = 1'b1;
            total_d    = '0;
          end
        end
      end
      PH_SKIP: begin
        remain_d = remain_q - 64'd1;
        if (remain_q == 64'd1) begin
          fail = 1'b1;
        end
      end
      PH_TIMECODE: begin
        if (remain_q == TC_LENGTH) begin
          tc_value_d = byte_i;
          remain_d   = 64'd1;
        end else begin
          remain_d = '0;
          phase_d  = PH_HEADER;
          if (byte_i != 8'h00) begin
            fail = 1'b1;
          end else begin
            res_valid_o = 1'b1;
            res_o.evt   = EVT_TIMECODE;
            res_o.data  = tc_value_q;
          end
        end
      end
      default: begin
        phase_d = PH_HEADER;
      end
    endcase
    // any error drops the packet and resyncs on a header
    if (fail) begin
      total_d     = '0;
      phase_d     = PH_HEADER;
      hdr_idx_d   = '0;
      res_valid_o = 1'b1;
      res_o       = '{evt: EVT_ERROR, data: '0, last: 1'b0, length: '0, err: fail_code};
    end
  end

  // parser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_HEADER;
      hdr_idx_q   <= '0;
      seg_type_q  <= '0;
      hdr_fault_q <= 1'b0;
      tc_fault_q  <= 1'b0;
      len_q       <= '0;
      remain_q    <= '0;
      total_q     <= '0;
      tc_value_q  <= '0;
    end else if (advance_i) begin
      phase_q     <= phase_d;
      hdr_idx_q   <= hdr_idx_d;
      seg_type_q  <= seg_type_d;
      hdr_fault_q <= hdr_fault_d;
      tc_fault_q  <= tc_fault_d;
      len_q       <= len_d;
      remain_q    <= remain_d;
      total_q     <= total_d;
      tc_value_q  <= tc_value_d;
    end
  end

`ifndef ASSERT_OFF
  // header position only moves while parsing a header
  a_idx_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q != PH_HEADER) |-> (hdr_idx_q == '0))
    else $error("header index nonzero outside header phase");

  // a payload or skip phase always has bytes left to consume
  a_remain_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_PAYLOAD || phase_q == PH_SKIP) |-> (remain_q != '0))
    else $error("payload phase with no bytes remaining");

  // end of packet clears the count and resyncs on a header
  a_last_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance_i && res_valid_o && res_o.last) |=>
      (phase_q == PH_HEADER && total_q == '0))
    else $error("packet end did not clear count or phase");
`endif

endmodule : tsd_parser
`default_nettype wire

// ----- rtl/tsd_out_stage.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tsd_out_stage
// Result register: holds one result until the downstream side takes it.
// ----------------------------------------------------------------------------
module tsd_out_stage
  import tsd_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic load_i,
  input  wire res_t res_i,
  input  wire logic ready_i,
  output logic      valid_o,
  output res_t      res_o
);

  logic valid_q;
  res_t res_q;

  // valid flag: set on load, cleared once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (ready_i) begin
      valid_q <= 1'b0;
    end
  end

  // result payload, no reset
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule : tsd_out_stage
`default_nettype wire

// ----- rtl/tcp_segment_deframer.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tcp_segment_deframer
// Length-prefixed segment deframer: parses 12-byte headers, forwards payload
// bytes, reports time codes and framing or capacity errors.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                    contents
//  s_axis    in         s_axis_tvalid/s_axis_tready  one stream byte
//  m_axis    out        m_axis_tvalid/m_axis_tready  byte, length, fault code, event
//  cfg       in         cfg_valid_i/cfg_ready_o      register index and value
//
//  One byte per cycle sustained while m_axis does not stall; each byte is held in
//  the input register and its result, if any, appears from the result register
//  the cycle after it leaves. Header bytes and skipped payload give only errors.
//  Reset clears the parser to the header phase and loads register defaults.
//  A result held by a stalled m_axis stops the parser; the input register
//  then takes a byte only while it is empty. cfg is always ready.
// ----------------------------------------------------------------------------
module tcp_segment_deframer
  import tsd_pkg::*;
#(
  parameter int unsigned TOTAL_COUNT_WIDTH = TSD_TOTAL_COUNT_WIDTH
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // input stream
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] in_byte
  // output stream
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [47:0]      m_axis_tdata,   // [7:0] out_byte, [39:8] packet_length,
                                           // [40] fault_code, [47:41] zero
  output logic             m_axis_tlast,
  output logic [1:0]       m_axis_tuser,   // [1:0] event_res
  // configuration writes
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [7:0]  cfg_index_i,
  input  wire logic [31:0] cfg_data_i
);

  cfg_t       cfg_q;
  logic       in_valid;
  logic [7:0] in_byte;
  logic       advance;
  logic       res_valid;
  res_t       res;
  res_t       out_res;

  // configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.capacity <= CAPACITY_RESET;
      cfg_q.enforce  <= ENFORCE_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      if (cfg_index_i == REG_BUFFER_CAPACITY) begin
        cfg_q.capacity <= cfg_data_i;
      end else if (cfg_index_i == REG_ENFORCE_CAPACITY) begin
        cfg_q.enforce <= cfg_data_i[0];
      end
    end
  end

  // the held byte moves when the result register can take its result
  assign advance = in_valid && (!m_axis_tvalid || m_axis_tready);

  tsd_in_stage u_in_stage (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (s_axis_tvalid),
    .ready_o  (s_axis_tready),
    .byte_i   (s_axis_tdata),
    .advance_i(advance),
    .valid_o  (in_valid),
    .byte_o   (in_byte)
  );

  tsd_parser #(
    .TOTAL_COUNT_WIDTH(TOTAL_COUNT_WIDTH)
  ) u_parser (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .advance_i  (advance),
    .byte_i     (in_byte),
    .cfg_i      (cfg_q),
    .res_valid_o(res_valid),
    .res_o      (res)
  );

  tsd_out_stage u_out_stage (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (advance && res_valid),
    .res_i  (res),
    .ready_i(m_axis_tready),
    .valid_o(m_axis_tvalid),
    .res_o  (out_res)
  );

  // output packing
  assign m_axis_tdata = {7'b0, out_res.err, out_res.length, out_res.data};
  assign m_axis_tlast = out_res.last;
  assign m_axis_tuser = out_res.evt;

endmodule : tcp_segment_deframer
`default_nettype wire

// ----- dv/deframe_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deframe_checker
// Watches the byte stream, the register writes and the result stream of the
// segment deframer. It predicts each result from the accepted bytes and
// compares every result field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module deframe_checker
  import tsd_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  // input stream as seen by the block
  input  logic              s_axis_tvalid,
  input  logic              s_axis_tready,
  input  logic [7:0]        s_axis_tdata,    // [7:0] in_byte
  // result stream as seen by the block
  input  logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  input  logic [47:0]       m_axis_tdata,    // [7:0] out_byte, [39:8] packet_length,
                                             // [40] fault_code, [47:41] zero
  input  logic              m_axis_tlast,
  input  logic [1:0]        m_axis_tuser,    // [1:0] event_res
  // register writes
  input  logic              cfg_valid_i,
  input  logic              cfg_ready_i,
  input  logic [7:0]        cfg_index_i,
  input  logic [31:0]       cfg_data_i,
  // status to the testbench top
  output int unsigned       fail_count_o,
  output int unsigned       pending_o
);

  typedef enum logic [1:0] {
    ST_HEADER,
    ST_PAYLOAD,
    ST_DISCARD,
    ST_TIMECODE
  } parse_e;

  // predicted registers
  logic [31:0] capacity = CAPACITY_RESET;
  logic        enforce  = ENFORCE_RESET;

  // predicted parser state
  parse_e                          st        = ST_HEADER;
  logic [3:0]                      hdr_idx   = '0;
  logic [7:0]                      seg_kind  = '0;
  logic                            hdr_bad   = 1'b0;
  logic                            tc_bad    = 1'b0;
  logic [63:0]                     len_acc   = '0;
  logic [63:0]                     remaining = '0;
  logic [TSD_TOTAL_COUNT_WIDTH-1:0] pkt_total = '0;
  logic [7:0]                      tc_value  = '0;

  res_t        due_results[$];
  int unsigned mismatches = 0;

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
  end

  // any error drops the packet and restarts header parsing
  function automatic bit raise_error(input err_e code, output res_t r);
    pkt_total = '0;
    st        = ST_HEADER;
    hdr_idx   = '0;
    r         = '0;
    r.evt     = EVT_ERROR;
    r.err     = code;
    return 1'b1;
  endfunction

  // advance the parser by one byte, returns 1 when a result is due
  function automatic bit deframe_byte(input logic [7:0] b, output res_t r);
    logic [63:0] room;
    r = '0;
    case (st)
      ST_HEADER: begin
        if (hdr_idx == 4'd0) begin
          seg_kind = b;
          hdr_bad  = !(b == SEG_FINAL || b == SEG_ABORT || b == SEG_CONTINUED ||
                       b == SEG_TIMECODE);
          tc_bad   = 1'b0;
          len_acc  = '0;
        end else if (hdr_idx == 4'd1 && b != 8'h00) begin
          hdr_bad = 1'b1;
        end
        // a time code header must read 0,...,0,2 from byte 2 on
        if (hdr_idx >= 4'd2 && ((hdr_idx < HDR_LAST_IDX) ? (b != 8'h00) : (b != TC_TAIL_BYTE)))
          tc_bad = 1'b1;
        if (hdr_idx >= HDR_LEN_IDX)
          len_acc = {len_acc[55:0], b};
        if (hdr_idx != HDR_LAST_IDX) begin
          hdr_idx = hdr_idx + 4'd1;
          return 1'b0;
        end
        hdr_idx = '0;
        if (hdr_bad || len_acc == 64'd0)
          return raise_error(ERR_BAD_MESSAGE, r);
        room = (64'(pkt_total) <= 64'(capacity)) ? 64'(capacity) - 64'(pkt_total) : 64'd0;
        if (enforce && len_acc > room)
          return raise_error(ERR_NO_BUFFER, r);
        remaining = len_acc;
        if (seg_kind == SEG_TIMECODE) begin
          if (tc_bad)
            return raise_error(ERR_BAD_MESSAGE, r);
          st = ST_TIMECODE;
        end else if (seg_kind == SEG_ABORT) begin
          st = ST_DISCARD;
        end else begin
          st = ST_PAYLOAD;
        end
        return 1'b0;
      end
      ST_PAYLOAD: begin
        if (pkt_total != '1)
          pkt_total = pkt_total + 1'b1;
        remaining = remaining - 64'd1;
        r.evt  = EVT_PAYLOAD;
        r.data = b;
        if (remaining == 64'd0) begin
          st = ST_HEADER;
          if (seg_kind == SEG_FINAL) begin
            r.last    = 1'b1;
            r.length  = 32'(pkt_total);
            pkt_total = '0;
            return 1'b1;
          end
        end
        r.length = 32'(pkt_total);
        return 1'b1;
      end
      ST_DISCARD: begin
        remaining = remaining - 64'd1;
        if (remaining == 64'd0)
          return raise_error(ERR_BAD_MESSAGE, r);
        return 1'b0;
      end
      default: begin
        // time code payload: value, then a byte that must be zero
        if (remaining == TC_LENGTH) begin
          tc_value  = b;
          remaining = 64'd1;
          return 1'b0;
        end
        remaining = '0;
        st        = ST_HEADER;
        if (b != 8'h00)
          return raise_error(ERR_BAD_MESSAGE, r);
        r.evt  = EVT_TIMECODE;
        r.data = tc_value;
        return 1'b1;
      end
    endcase
  endfunction

  task automatic compare_field(input string what, input logic [31:0] want,
                               input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
      mismatches++;
    end
  endtask

  // sample all channels at the clock edge
  always @(posedge clk_i or negedge rst_ni) begin
    res_t want;
    if (!rst_ni) begin
      capacity  = CAPACITY_RESET;
      enforce   = ENFORCE_RESET;
      st        = ST_HEADER;
      hdr_idx   = '0;
      seg_kind  = '0;
      hdr_bad   = 1'b0;
      tc_bad    = 1'b0;
      len_acc   = '0;
      remaining = '0;
      pkt_total = '0;
      tc_value  = '0;
      due_results.delete();
    end else begin
      // results first: nothing accepted at this edge can already be out
      if (m_axis_tvalid && m_axis_tready) begin
        if (due_results.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual event %0d data %0h",
                   $time, m_axis_tuser, m_axis_tdata[7:0],
                   " last %0b length %0h fault code %0b",
                   m_axis_tlast, m_axis_tdata[39:8], m_axis_tdata[40]);
          mismatches++;
        end else begin
          want = due_results.pop_front();
          compare_field("event_res", 32'(want.evt), 32'(m_axis_tuser));
          compare_field("out_byte", 32'(want.data), 32'(m_axis_tdata[7:0]));
          compare_field("last", 32'(want.last), 32'(m_axis_tlast));
          compare_field("packet_length", want.length, m_axis_tdata[39:8]);
          compare_field("fault_code", 32'(want.err), 32'(m_axis_tdata[40]));
        end
      end
      // register writes, unknown indexes are ignored
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i == REG_BUFFER_CAPACITY)
          capacity = cfg_data_i;
        else if (cfg_index_i == REG_ENFORCE_CAPACITY)
          enforce = cfg_data_i[0];
      end
      // stream byte transaction
      if (s_axis_tvalid && s_axis_tready) begin
        if (deframe_byte(s_axis_tdata, want))
          due_results.push_back(want);
      end
    end
    fail_count_o <= mismatches;
    pending_o    <= due_results.size();
  end

endmodule : deframe_checker

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stream testbench of the segment deframer: drives directed and random
// segment sequences under several register settings with random idling on
// both streams, and reports the verdict of the checker.
// ----------------------------------------------------------------------------
module tb_top;
  import tsd_pkg::*;

  localparam int unsigned SETTLE_CYCLES = 16;
  localparam int unsigned LIMIT_NS      = 2_000_000;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = '0;     // [7:0] in_byte
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;           // [7:0] out_byte, [39:8] packet_length,
                                       // [40] fault_code, [47:41] zero
  logic        m_axis_tlast;
  logic [1:0]  m_axis_tuser;           // [1:0] event_res
  logic        cfg_valid_i   = 1'b0;
  logic        cfg_ready_o;
  logic [7:0]  cfg_index_i   = '0;
  logic [31:0] cfg_data_i    = '0;

  int unsigned fail_count;
  int unsigned pending;

  // stimulus bookkeeping: register copies and bytes of the open packet
  logic [63:0] cap_mirror = 64'(CAPACITY_RESET);
  logic        enf_mirror = ENFORCE_RESET;
  logic [63:0] pkt_bytes  = '0;
  int unsigned sent       = 0;
  bit          quiet      = 1'b0;

  always #1 clk_i = ~clk_i;

  tcp_segment_deframer uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  deframe_checker chk (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_i   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .fail_count_o  (fail_count),
    .pending_o     (pending)
  );

  // one byte transaction, with an occasional idle burst in front
  task automatic put(input logic [7:0] b);
    if (!quiet && $urandom_range(0, 7) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    do @(posedge clk_i); while (!s_axis_tready);
    sent++;
  endtask

  task automatic put_header(input logic [7:0] kind, input logic [7:0] b1,
                            input logic [15:0] mid, input logic [63:0] len);
    put(kind);
    put(b1);
    put(mid[15:8]);
    put(mid[7:0]);
    for (int i = 7; i >= 0; i--)
      put(len[8*i +: 8]);
  endtask

  function automatic logic [63:0] room_left();
    return (pkt_bytes <= cap_mirror) ? cap_mirror - pkt_bytes : 64'd0;
  endfunction

  function automatic bit fits(input logic [63:0] len);
    return !enf_mirror || len <= room_left();
  endfunction

  // final, continued or error-ended segment; payload only when it is taken
  task automatic data_segment(input logic [7:0] kind, input logic [63:0] len);
    put_header(kind, 8'h00, 16'($urandom), len);
    if (len == 64'd0 || !fits(len)) begin
      pkt_bytes = '0;
    end else begin
      repeat (len) put(8'($urandom));
      if (kind == SEG_CONTINUED)
        pkt_bytes = pkt_bytes + len;
      else
        pkt_bytes = '0;
    end
  endtask

  task automatic time_code(input logic [7:0] value, input logic [7:0] tail);
    put_header(SEG_TIMECODE, 8'h00, 16'h0000, TC_LENGTH);
    if (fits(TC_LENGTH)) begin
      put(value);
      put(tail);
      if (tail != 8'h00)
        pkt_bytes = '0;
    end else begin
      pkt_bytes = '0;
    end
  endtask

  // time code header with one byte of the fixed tail spoiled
  task automatic broken_time_code();
    logic [15:0] mid;
    logic [63:0] len;
    int unsigned pos;
    logic [7:0]  flip;
    mid  = '0;
    len  = TC_LENGTH;
    pos  = $urandom_range(2, 11);
    flip = 8'($urandom_range(1, 255));
    if (pos < 4)
      mid[8*(3-pos) +: 8] = flip;
    else
      len[8*(11-pos) +: 8] = len[8*(11-pos) +: 8] ^ flip;
    put_header(SEG_TIMECODE, 8'h00, mid, len);
    pkt_bytes = '0;
  endtask

  // random header bytes, forced to a bad type or a bad second byte
  task automatic noise_header();
    logic [7:0] kind;
    logic [7:0] b1;
    kind = 8'($urandom);
    b1   = 8'($urandom);
    if ((kind == SEG_FINAL || kind == SEG_ABORT || kind == SEG_CONTINUED ||
         kind == SEG_TIMECODE) && b1 == 8'h00)
      kind = kind | 8'h80;
    put_header(kind, b1, 16'($urandom), {32'($urandom), 32'($urandom)});
    pkt_bytes = '0;
  endtask

  // mostly well-formed packets, the rest broken segments and noise
  task automatic random_segment();
    int unsigned pick;
    logic [7:0]  kind;
    logic [63:0] len;
    pick = $urandom_range(0, 99);
    kind = $urandom_range(0, 1) ? SEG_FINAL : SEG_CONTINUED;
    len  = ($urandom_range(0, 9) == 0) ? 64'($urandom_range(17, 80))
                                       : 64'($urandom_range(1, 16));
    if (pick < 56)
      data_segment(kind, len);
    else if (pick < 68)
      time_code(8'($urandom), 8'h00);
    else if (pick < 72)
      time_code(8'($urandom), 8'($urandom_range(1, 255)));
    else if (pick < 76)
      broken_time_code();
    else if (pick < 84)
      data_segment(SEG_ABORT, 64'($urandom_range(1, 8)));
    else if (pick < 87)
      data_segment(($urandom_range(0, 2) == 0) ? SEG_ABORT : kind, 64'd0);
    else if (pick < 92 && enf_mirror) begin
      if ($urandom_range(0, 1))
        len = room_left() + 64'd1 + 64'($urandom_range(0, 3));
      else
        len = {1'b1, 31'($urandom), 32'($urandom)};
      data_segment(kind, len);
    end else
      noise_header();
  endtask

  task automatic random_until(input int unsigned target);
    while (sent < target)
      random_segment();
  endtask

  // stop sending and let every predicted result come out
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // both registers, spare upper bits and an unknown index, block idle only
  task automatic configure(input logic [31:0] cap, input logic enf);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= REG_BUFFER_CAPACITY;
    cfg_data_i  <= cap;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_index_i <= REG_ENFORCE_CAPACITY;
    cfg_data_i  <= {31'($urandom), enf};
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_index_i <= 8'($urandom_range(2, 255));
    cfg_data_i  <= $urandom;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    cap_mirror = 64'(cap);
    enf_mirror = enf;
  endtask

  // result side: random stall bursts, none in the last part
  initial begin
    forever begin
      if (!quiet && $urandom_range(0, 2) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      repeat ($urandom_range(1, 24)) @(posedge clk_i);
    end
  end

  initial begin
    #(LIMIT_NS);
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // directed cases under the reset settings
    put_header(SEG_FINAL, 8'h00, 16'hFFFF, 64'd2);
    put(8'h00);
    put(8'hFF);
    data_segment(SEG_CONTINUED, 64'd3);
    data_segment(SEG_FINAL, 64'd2);
    time_code(8'hFF, 8'h00);
    time_code(8'h00, 8'h00);
    time_code(8'h5A, 8'h01);
    put_header(SEG_TIMECODE, 8'h00, 16'h0000, 64'd3);
    broken_time_code();
    put_header(8'h03, 8'h00, 16'h0000, 64'd1);
    put_header(8'hFF, 8'h00, 16'h0000, 64'd1);
    put_header(SEG_FINAL, 8'h80, 16'h0000, 64'd1);
    pkt_bytes = '0;
    data_segment(SEG_FINAL, 64'd0);
    data_segment(SEG_ABORT, 64'd2);
    // an error in the middle drops the packet count
    data_segment(SEG_CONTINUED, 64'd2);
    noise_header();
    data_segment(SEG_FINAL, 64'd1);
    data_segment(SEG_FINAL, 64'd4097);
    data_segment(SEG_CONTINUED, '1);
    random_until(600);

    // smallest capacity
    drain();
    configure(32'd1, 1'b1);
    data_segment(SEG_FINAL, 64'd1);
    data_segment(SEG_CONTINUED, 64'd1);
    data_segment(SEG_FINAL, 64'd1);
    data_segment(SEG_FINAL, 64'd2);
    random_until(800);

    // largest capacity
    drain();
    configure(32'hFFFF_FFFF, 1'b1);
    data_segment(SEG_FINAL, 64'h1_0000_0000);
    data_segment(SEG_CONTINUED, 64'h0000_FFFF_0000_0000);
    random_until(1050);

    // no enforcement, then a packet already beyond the capacity
    drain();
    configure(32'd40, 1'b0);
    random_until(1300);
    data_segment(SEG_CONTINUED, 64'd50);
    drain();
    configure(32'd40, 1'b1);
    data_segment(SEG_CONTINUED, 64'd1);

    // last part without idling
    drain();
    configure(32'($urandom_range(16, 300)), 1'b1);
    quiet = 1'b1;
    random_until(1650);
    drain();

    if (fail_count == 0 && pending == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule : tb_top
